// File: rtl/apqm_pkg.sv
package apqm_pkg;

    // Datapath widths.
    localparam int ACC_W   = 54;
    localparam int ERR_W   = 26;
    localparam int VEL_W   = 25;
    localparam int ISUM_W  = 40;
    localparam int MUL_A_W = 27;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int CNT_W   = 12;
    localparam int XS_W    = 21;

    // Register file indices.
    localparam logic [3:0] REG_PITCH_KP    = 4'd0;
    localparam logic [3:0] REG_PITCH_KD    = 4'd1;
    localparam logic [3:0] REG_PITCH_KI    = 4'd2;
    localparam logic [3:0] REG_ROLL_KP     = 4'd3;
    localparam logic [3:0] REG_ROLL_KD     = 4'd4;
    localparam logic [3:0] REG_ROLL_KI     = 4'd5;
    localparam logic [3:0] REG_HOVER       = 4'd6;
    localparam logic [3:0] REG_INTEG_LIMIT = 4'd7;

    typedef struct packed {
        logic [21:0] pitch_kp;
        logic [21:0] pitch_kd;
        logic [21:0] pitch_ki;
        logic [21:0] roll_kp;
        logic [21:0] roll_kd;
        logic [21:0] roll_ki;
        logic [10:0] hover_us;
        logic [17:0] integ_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        pitch_kp:    22'd98304,
        pitch_kd:    22'd1433600,
        pitch_ki:    22'd205,
        roll_kp:     22'd49152,
        roll_kd:     22'd1740800,
        roll_ki:     22'd287,
        hover_us:    11'd1600,
        integ_limit: 18'd38400
    };

    // Pulse limits in Q.20 microseconds and the matching counts.
    localparam logic signed [ACC_W-1:0] PULSE_LO = ACC_W'(64'd1000 << 20);
    localparam logic signed [ACC_W-1:0] PULSE_HI = ACC_W'(64'd1850 << 20);
    localparam logic [30:0] COUNT_HALF = 31'd320000;
    localparam logic [22:0] RECIP_625  = 23'd6871947;
    localparam logic [9:0]  DIV_625    = 10'd625;
    localparam logic [CNT_W-1:0] CNT_MIN = 12'd1638;
    localparam logic [CNT_W-1:0] CNT_MAX = 12'd3031;

    typedef logic signed [12:0] off_tab_t [256];
    typedef logic signed [29:0] thr_tab_t [256];

    // Stick to angle offset, round half up of (s-128)*3840/224.
    function automatic off_tab_t gen_off_tab();
        off_tab_t tab;
        longint   n;
        longint   q;
        for (int i = 0; i < 256; i++) begin
            n = 2 * (longint'(i) - 128) * 3840 + 224;
            q = n / 448;
            if (n % 448 < 0) begin
                q = q - 1;
            end
            tab[i] = 13'(q);
        end
        return tab;
    endfunction

    // Stick to thrust offset in Q.20, round half up of (s-128)*200*2^20/112.
    function automatic thr_tab_t gen_thr_tab();
        thr_tab_t tab;
        longint   n;
        longint   q;
        for (int i = 0; i < 256; i++) begin
            n = 2 * (longint'(i) - 128) * 200 * 1048576 + 112;
            q = n / 224;
            if (n % 224 < 0) begin
                q = q - 1;
            end
            tab[i] = 30'(q);
        end
        return tab;
    endfunction

    localparam off_tab_t OFF_TAB = gen_off_tab();
    localparam thr_tab_t THR_TAB = gen_thr_tab();

endpackage

// File: rtl/attitude_pid_quad_motor_mixer_top.sv
// Attitude PID with X-layout motor mixer around one shared 27x24 multiplier.
// s_ready is high only while the sequencer idles, since the multiplier is reused for
// six gain products and four count divisions; a new tick is taken only after the
// previous result has been loaded into the output register.
// Reset (synchronous, aresetn low): gains return to defaults, previous angles and
// both integrals clear to zero, no result is pending.
module attitude_pid_quad_motor_mixer_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [23:0]         s_roll_measured,
    input  logic signed [23:0]         s_pitch_measured,
    input  logic signed [23:0]         s_yaw_rate_measured,
    input  logic signed [23:0]         s_roll_setpoint,
    input  logic signed [23:0]         s_pitch_setpoint,
    input  logic signed [23:0]         s_yaw_rate_setpoint,
    input  logic [7:0]                 s_stick_roll,
    input  logic [7:0]                 s_stick_pitch,
    input  logic [7:0]                 s_stick_thrust,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [11:0]                m_motor0_count,
    output logic [11:0]                m_motor1_count,
    output logic [11:0]                m_motor2_count,
    output logic [11:0]                m_motor3_count,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [3:0]                 cfg_index,
    input  logic [21:0]                cfg_data
);
    import apqm_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE = 12'b000000000001,
        ST_ERR  = 12'b000000000010,
        ST_MP   = 12'b000000000100,
        ST_MD   = 12'b000000001000,
        ST_MI   = 12'b000000010000,
        ST_INT  = 12'b000000100000,
        ST_ACC  = 12'b000001000000,
        ST_YT   = 12'b000010000000,
        ST_MOT  = 12'b000100000000,
        ST_DIVM = 12'b001000000000,
        ST_DIVC = 12'b010000000000,
        ST_OUT  = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic   axis_reg;
    logic [1:0] motor_reg;
    logic   m_valid_reg;
    logic   out_load;

    cfg_t cfg;

    // Captured tick.
    logic signed [23:0] roll_meas_reg, pitch_meas_reg, yaw_meas_reg;
    logic signed [23:0] roll_sp_reg, pitch_sp_reg, yaw_sp_reg;
    logic [7:0]         stick_roll_reg, stick_pitch_reg, stick_thrust_reg;

    // Controller state.
    logic signed [23:0] last_roll_reg, last_pitch_reg;
    logic signed [23:0] roll_integ_reg, pitch_integ_reg;

    // Working registers.
    logic signed [ERR_W-1:0] err_reg;
    logic signed [VEL_W-1:0] vel_reg;
    logic signed [ACC_W-1:0] acc_reg, term_r_reg, term_p_reg;
    logic signed [ACC_W-1:0] t_reg, y_reg, sum_reg, dif_reg;
    logic [30:0]             clip_reg;
    logic [XS_W-1:0]         xs_reg;
    logic [CNT_W-1:0]        cnt_reg [4];
    logic [CNT_W-1:0]        m_cnt_reg [4];

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod_reg;

    apqm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    apqm_mul u_mul (
        .aclk     (aclk),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_reg (prod_reg)
    );

    // Per-axis operand selection (roll first, then pitch).
    logic signed [23:0] ax_meas, ax_sp, ax_last, ax_integ;
    logic [7:0]         ax_stick;
    logic [21:0]        ax_kp, ax_kd, ax_ki;

    always_comb begin
        if (axis_reg) begin
            ax_meas  = pitch_meas_reg;
            ax_sp    = pitch_sp_reg;
            ax_last  = last_pitch_reg;
            ax_integ = pitch_integ_reg;
            ax_stick = stick_pitch_reg;
            ax_kp    = cfg.pitch_kp;
            ax_kd    = cfg.pitch_kd;
            ax_ki    = cfg.pitch_ki;
        end else begin
            ax_meas  = roll_meas_reg;
            ax_sp    = roll_sp_reg;
            ax_last  = last_roll_reg;
            ax_integ = roll_integ_reg;
            ax_stick = stick_roll_reg;
            ax_kp    = cfg.roll_kp;
            ax_kd    = cfg.roll_kd;
            ax_ki    = cfg.roll_ki;
        end
    end

    // Error and velocity of the current axis.
    logic signed [ERR_W-1:0] err_calc;
    logic signed [VEL_W-1:0] vel_calc;

    assign err_calc = ERR_W'(ax_sp) + ERR_W'(OFF_TAB[ax_stick]) - ERR_W'(ax_meas);
    assign vel_calc = VEL_W'(ax_meas) - VEL_W'(ax_last);

    // Integral update: add the rounded product, then clamp to the limit.
    logic signed [MUL_P_W-1:0] i_step;
    logic signed [ISUM_W-1:0]  i_sum, i_lim, i_clamped;

    assign i_step = (prod_reg + MUL_P_W'(2048)) >>> 12;
    assign i_sum  = ISUM_W'(ax_integ) + ISUM_W'(i_step);
    assign i_lim  = ISUM_W'($signed({1'b0, cfg.integ_limit}));

    always_comb begin
        if (i_sum > i_lim) begin
            i_clamped = i_lim;
        end else if (i_sum < -i_lim) begin
            i_clamped = -i_lim;
        end else begin
            i_clamped = i_sum;
        end
    end

    // Thrust and yaw terms.
    logic signed [ACC_W-1:0] t_calc, y_calc;
    logic signed [VEL_W-1:0] yaw_diff;

    assign yaw_diff = VEL_W'(yaw_sp_reg) - VEL_W'(yaw_meas_reg);
    assign y_calc   = ACC_W'(yaw_diff) <<< 12;
    assign t_calc   = ACC_W'($signed({1'b0, cfg.hover_us, 20'd0}))
                    - ACC_W'(THR_TAB[stick_thrust_reg]);

    // Mixer for the current motor, then clamp to the pulse range.
    logic signed [ACC_W-1:0] mix, mix_clamped;

    always_comb begin
        unique case (motor_reg)
            2'd0:    mix = (t_reg - y_reg) + dif_reg;
            2'd1:    mix = (t_reg + y_reg) - sum_reg;
            2'd2:    mix = (t_reg + y_reg) + sum_reg;
            default: mix = (t_reg - y_reg) - dif_reg;
        endcase
        if (mix < PULSE_LO) begin
            mix_clamped = PULSE_LO;
        end else if (mix > PULSE_HI) begin
            mix_clamped = PULSE_HI;
        end else begin
            mix_clamped = mix;
        end
    end

    // Count = floor((c + 320000) / 640000), done as /1024 then reciprocal of 625.
    logic [30:0]      biased;
    logic [XS_W-1:0]  xs_calc;
    logic [CNT_W-1:0] q_est, q_fix;
    logic [21:0]      rem;

    assign biased  = clip_reg + COUNT_HALF;
    assign xs_calc = biased[30:10];
    assign q_est   = prod_reg[43:32];
    assign rem     = 22'(xs_reg) - 22'(q_est) * 22'(DIV_625);
    assign q_fix   = (rem >= 22'(DIV_625)) ? q_est + 12'd1 : q_est;

    // Multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MP: begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = MUL_B_W'($signed({1'b0, ax_kp}));
            end
            ST_MD: begin
                mul_a = MUL_A_W'(vel_reg);
                mul_b = MUL_B_W'($signed({1'b0, ax_kd}));
            end
            ST_MI: begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = MUL_B_W'($signed({1'b0, ax_ki}));
            end
            ST_DIVM: begin
                mul_a = MUL_A_W'($signed({1'b0, xs_calc}));
                mul_b = MUL_B_W'($signed({1'b0, RECIP_625}));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer.
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_ERR;
            ST_ERR:  state_next = ST_MP;
            ST_MP:   state_next = ST_MD;
            ST_MD:   state_next = ST_MI;
            ST_MI:   state_next = ST_INT;
            ST_INT:  state_next = ST_ACC;
            ST_ACC:  state_next = axis_reg ? ST_YT : ST_ERR;
            ST_YT:   state_next = ST_MOT;
            ST_MOT:  state_next = ST_DIVM;
            ST_DIVM: state_next = ST_DIVC;
            ST_DIVC: state_next = (motor_reg == 2'd3) ? ST_OUT : ST_MOT;
            ST_OUT:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and controller state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            axis_reg        <= 1'b0;
            motor_reg       <= 2'd0;
            m_valid_reg     <= 1'b0;
            last_roll_reg   <= '0;
            last_pitch_reg  <= '0;
            roll_integ_reg  <= '0;
            pitch_integ_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE) begin
                axis_reg  <= 1'b0;
                motor_reg <= 2'd0;
            end
            if (state_reg == ST_ACC) begin
                axis_reg <= 1'b1;
            end
            if (state_reg == ST_DIVC) begin
                motor_reg <= motor_reg + 2'd1;
            end
            if (state_reg == ST_ERR) begin
                if (axis_reg) begin
                    last_pitch_reg <= ax_meas;
                end else begin
                    last_roll_reg <= ax_meas;
                end
            end
            if (state_reg == ST_INT) begin
                if (axis_reg) begin
                    pitch_integ_reg <= i_clamped[23:0];
                end else begin
                    roll_integ_reg <= i_clamped[23:0];
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            roll_meas_reg    <= s_roll_measured;
            pitch_meas_reg   <= s_pitch_measured;
            yaw_meas_reg     <= s_yaw_rate_measured;
            roll_sp_reg      <= s_roll_setpoint;
            pitch_sp_reg     <= s_pitch_setpoint;
            yaw_sp_reg       <= s_yaw_rate_setpoint;
            stick_roll_reg   <= s_stick_roll;
            stick_pitch_reg  <= s_stick_pitch;
            stick_thrust_reg <= s_stick_thrust;
        end
        if (state_reg == ST_ERR) begin
            err_reg <= err_calc;
            vel_reg <= vel_calc;
        end
        if (state_reg == ST_MD) begin
            acc_reg <= ACC_W'(prod_reg);
        end
        if (state_reg == ST_MI) begin
            acc_reg <= acc_reg - ACC_W'(prod_reg);
        end
        if (state_reg == ST_ACC) begin
            if (axis_reg) begin
                term_p_reg <= acc_reg + (ACC_W'(ax_integ) <<< 12);
            end else begin
                term_r_reg <= acc_reg + (ACC_W'(ax_integ) <<< 12);
            end
        end
        if (state_reg == ST_YT) begin
            t_reg   <= t_calc;
            y_reg   <= y_calc;
            sum_reg <= term_p_reg + term_r_reg;
            dif_reg <= term_p_reg - term_r_reg;
        end
        if (state_reg == ST_MOT) begin
            clip_reg <= mix_clamped[30:0];
        end
        if (state_reg == ST_DIVM) begin
            xs_reg <= xs_calc;
        end
        if (state_reg == ST_DIVC) begin
            cnt_reg[motor_reg] <= q_fix;
        end
        if (out_load) begin
            for (int k = 0; k < 4; k++) begin
                m_cnt_reg[k] <= cnt_reg[k];
            end
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_motor0_count = m_cnt_reg[0];
    assign m_motor1_count = m_cnt_reg[1];
    assign m_motor2_count = m_cnt_reg[2];
    assign m_motor3_count = m_cnt_reg[3];

    // An accepted beat always starts the roll axis.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_ERR && !axis_reg)
        else $error("tick accepted without starting the roll axis");

    // The reciprocal estimate is never more than one below the quotient.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIVC |-> rem < 22'(2 * 625))
        else $error("count reciprocal estimate out of range");

    // Clamped pulses of motors 0 and 3 always land inside the count range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_motor0_count >= CNT_MIN && m_motor0_count <= CNT_MAX
                 && m_motor3_count >= CNT_MIN && m_motor3_count <= CNT_MAX)
        else $error("motor count outside the pulse range");

endmodule

// File: rtl/apqm_mul.sv
module apqm_mul (
    input  logic                                 aclk,
    input  logic signed [apqm_pkg::MUL_A_W-1:0]  op_a,
    input  logic signed [apqm_pkg::MUL_B_W-1:0]  op_b,
    output logic signed [apqm_pkg::MUL_P_W-1:0]  prod_reg
);
    import apqm_pkg::*;

    // Shared signed multiplier with a registered product.
    always_ff @(posedge aclk) begin
        prod_reg <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
    end

endmodule

// File: rtl/apqm_cfg.sv
module apqm_cfg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [3:0]          cfg_index,
    input  logic [21:0]         cfg_data,
    output apqm_pkg::cfg_t      cfg
);
    import apqm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg         = cfg_reg;

    // Decode one write beat; unknown indices are dropped.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_PITCH_KP:    cfg_next.pitch_kp    = cfg_data;
                REG_PITCH_KD:    cfg_next.pitch_kd    = cfg_data;
                REG_PITCH_KI:    cfg_next.pitch_ki    = cfg_data;
                REG_ROLL_KP:     cfg_next.roll_kp     = cfg_data;
                REG_ROLL_KD:     cfg_next.roll_kd     = cfg_data;
                REG_ROLL_KI:     cfg_next.roll_ki     = cfg_data;
                REG_HOVER:       cfg_next.hover_us    = cfg_data[10:0];
                REG_INTEG_LIMIT: cfg_next.integ_limit = cfg_data[17:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: tb/tb_attitude_pid_quad_motor_mixer_top.sv
module tb_attitude_pid_quad_motor_mixer_top;
    import apqm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int    N_REGS       = 8;
    localparam int    N_PHASES     = 7;
    localparam int    PHASE_TICKS  = 257;
    localparam int    SETTLE_CYC   = 40;
    localparam longint Q20         = 64'd1048576;

    typedef struct packed {
        logic signed [23:0] roll_meas;
        logic signed [23:0] pitch_meas;
        logic signed [23:0] yaw_meas;
        logic signed [23:0] roll_sp;
        logic signed [23:0] pitch_sp;
        logic signed [23:0] yaw_sp;
        logic [7:0]         st_roll;
        logic [7:0]         st_pitch;
        logic [7:0]         st_thrust;
    } tick_t;

    localparam int TICK_W = $bits(tick_t);

    typedef logic [3:0][11:0] motors_t;

    typedef struct {
        tick_t   tick;
        logic    typed;
        motors_t counts;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    tick_t       s_tick;
    logic        m_valid;
    logic        m_ready;
    logic [11:0] m_motor0_count;
    logic [11:0] m_motor1_count;
    logic [11:0] m_motor2_count;
    logic [11:0] m_motor3_count;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_index;
    logic [21:0] cfg_data;

    // Predictor state: register copies, previous angles and integrals.
    longint  gain_reg [N_REGS];
    longint  last_roll_q, last_pitch_q, roll_integ_q, pitch_integ_q;
    motors_t motor_q [$];
    int      error_count;
    int      ticks_sent;
    int      beats_checked;
    int      saturated_beats;
    row_t    directed_rows [$];

    attitude_pid_quad_motor_mixer_top u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_roll_measured    (s_tick.roll_meas),
        .s_pitch_measured   (s_tick.pitch_meas),
        .s_yaw_rate_measured(s_tick.yaw_meas),
        .s_roll_setpoint    (s_tick.roll_sp),
        .s_pitch_setpoint   (s_tick.pitch_sp),
        .s_yaw_rate_setpoint(s_tick.yaw_sp),
        .s_stick_roll       (s_tick.st_roll),
        .s_stick_pitch      (s_tick.st_pitch),
        .s_stick_thrust     (s_tick.st_thrust),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_motor0_count     (m_motor0_count),
        .m_motor1_count     (m_motor1_count),
        .m_motor2_count     (m_motor2_count),
        .m_motor3_count     (m_motor3_count),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Floor division, then round half up built on it.
    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if (a % b < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic longint round_div(longint a, longint b);
        return floor_div(2 * a + b, 2 * b);
    endfunction

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // One PID axis in Q.20; updates the previous angle and the integral.
    function automatic longint pid_axis_term(input longint sp, input longint stick,
                                             input longint meas, inout longint last,
                                             inout longint integ, input longint kp,
                                             input longint kd, input longint ki);
        longint lim;
        longint offset;
        longint err;
        longint vel;
        lim    = gain_reg[REG_INTEG_LIMIT];
        offset = round_div((stick - 128) * 3840, 224);
        err    = sp + offset - meas;
        vel    = meas - last;
        integ  = clamp_to(integ + round_div(err * ki, 4096), -lim, lim);
        last   = meas;
        return err * kp - vel * kd + integ * 4096;
    endfunction

    // Full tick: two PID axes, yaw P term, thrust, X mix, clamp and count.
    function automatic motors_t predict_motor_counts(tick_t t);
        longint  r, p, y, thr, m, c;
        motors_t res;
        r = pid_axis_term(longint'(t.roll_sp), longint'(t.st_roll), longint'(t.roll_meas),
                          last_roll_q, roll_integ_q, gain_reg[REG_ROLL_KP],
                          gain_reg[REG_ROLL_KD], gain_reg[REG_ROLL_KI]);
        p = pid_axis_term(longint'(t.pitch_sp), longint'(t.st_pitch),
                          longint'(t.pitch_meas), last_pitch_q, pitch_integ_q,
                          gain_reg[REG_PITCH_KP], gain_reg[REG_PITCH_KD],
                          gain_reg[REG_PITCH_KI]);
        y   = (longint'(t.yaw_sp) - longint'(t.yaw_meas)) * 4096;
        thr = gain_reg[REG_HOVER] * Q20
              - round_div((longint'(t.st_thrust) - 128) * 200 * Q20, 112);
        for (int i = 0; i < 4; i++) begin
            case (i)
                0: m = thr - y - r + p;
                1: m = thr + y - r - p;
                2: m = thr + y + r + p;
                default: m = thr - y + r - p;
            endcase
            c = clamp_to(m, 1000 * Q20, 1850 * Q20);
            res[i] = 12'((c + 320000) / 640000);
        end
        return res;
    endfunction

    function automatic motors_t four_counts(int a, int b, int c, int d);
        motors_t res;
        res[0] = 12'(a);
        res[1] = 12'(b);
        res[2] = 12'(c);
        res[3] = 12'(d);
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
    endtask

    // Result checker: a beat moves when valid and ready are both high at the next edge.
    always @(negedge aclk) begin
        motors_t want;
        motors_t got;
        if (aresetn && m_valid && m_ready) begin
            got = four_counts(m_motor0_count, m_motor1_count, m_motor2_count,
                              m_motor3_count);
            if (motor_q.size() == 0) begin
                report_mismatch("unexpected result beat", 1, 0);
            end else begin
                want = motor_q.pop_front();
                beats_checked++;
                if (got[0] == CNT_MIN || got[0] == CNT_MAX) begin
                    saturated_beats++;
                end
                for (int i = 0; i < 4; i++) begin
                    if (got[i] !== want[i]) begin
                        report_mismatch($sformatf("motor%0d count", i), got[i], want[i]);
                    end
                end
            end
        end
    end

    // Receiver back-pressure cycles through four ready patterns, the first with no stalls.
    int unsigned rx_cycle;
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        case (rx_cycle[9:8])
            2'd0:    m_ready <= 1'b1;
            2'd1:    m_ready <= 1'($urandom_range(0, 1));
            2'd2:    m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Register write: predictor copy follows the masked value.
    task automatic write_reg(logic [3:0] idx, logic [21:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_HOVER:       gain_reg[idx] = longint'(data[10:0]);
            REG_INTEG_LIMIT: gain_reg[idx] = longint'(data[17:0]);
            default: begin
                if (idx < N_REGS) begin
                    gain_reg[idx] = longint'(data);
                end
            end
        endcase
    endtask

    // Present one tick beat and hold it until accepted; caller sits at a rising edge.
    task automatic send_tick(tick_t t, logic typed, motors_t typed_counts);
        motors_t predicted;
        s_tick  <= t;
        s_valid <= 1'b1;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        predicted = predict_motor_counts(t);
        motor_q.push_back(typed ? typed_counts : predicted);
        ticks_sent++;
    endtask

    task automatic drain_results();
        while (motor_q.size() > 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    function automatic tick_t random_tick();
        tick_t t;
        if ($urandom_range(0, 4) == 0) begin
            t = TICK_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom});
        end else begin
            t.roll_meas  = 24'($signed($urandom_range(0, 15360)) - 7680);
            t.pitch_meas = 24'($signed($urandom_range(0, 15360)) - 7680);
            t.yaw_meas   = 24'($signed($urandom_range(0, 102400)) - 51200);
            t.roll_sp    = 24'($signed($urandom_range(0, 7680)) - 3840);
            t.pitch_sp   = 24'($signed($urandom_range(0, 7680)) - 3840);
            t.yaw_sp     = 24'($signed($urandom_range(0, 51200)) - 25600);
            t.st_roll    = 8'($urandom_range(96, 160));
            t.st_pitch   = 8'($urandom_range(96, 160));
            t.st_thrust  = 8'($urandom_range(80, 176));
        end
        return t;
    endfunction

    function automatic row_t mk_row(longint rm, longint pm, longint ym, longint rs,
                                    longint ps, longint ys, int sr, int sp, int st,
                                    logic typed, motors_t counts);
        row_t r;
        r.tick   = '{24'(rm), 24'(pm), 24'(ym), 24'(rs), 24'(ps), 24'(ys),
                     8'(sr), 8'(sp), 8'(st)};
        r.typed  = typed;
        r.counts = counts;
        return r;
    endfunction

    // Stimulus: directed table, then random phases over several register settings.
    initial begin
        logic [21:0] data;
        int          burst_left;
        motors_t     none;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_tick        = '0;
        m_ready       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        rx_cycle      = 0;
        error_count   = 0;
        ticks_sent    = 0;
        beats_checked = 0;
        saturated_beats = 0;
        none          = '0;
        gain_reg[REG_PITCH_KP]    = CFG_RESET.pitch_kp;
        gain_reg[REG_PITCH_KD]    = CFG_RESET.pitch_kd;
        gain_reg[REG_PITCH_KI]    = CFG_RESET.pitch_ki;
        gain_reg[REG_ROLL_KP]     = CFG_RESET.roll_kp;
        gain_reg[REG_ROLL_KD]     = CFG_RESET.roll_kd;
        gain_reg[REG_ROLL_KI]     = CFG_RESET.roll_ki;
        gain_reg[REG_HOVER]       = CFG_RESET.hover_us;
        gain_reg[REG_INTEG_LIMIT] = CFG_RESET.integ_limit;
        last_roll_q   = 0;
        last_pitch_q  = 0;
        roll_integ_q  = 0;
        pitch_integ_q = 0;

        // Level flight at rest and the thrust and yaw extremes are read off directly.
        directed_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 128, 128, 128, 1'b1,
                                       four_counts(2621, 2621, 2621, 2621)));
        directed_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 128, 128, 0, 1'b1,
                                       four_counts(2996, 2996, 2996, 2996)));
        directed_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 128, 128, 255, 1'b1,
                                       four_counts(2250, 2250, 2250, 2250)));
        directed_rows.push_back(mk_row(0, 0, 0, 0, 0, 8388607, 128, 128, 128, 1'b1,
                                       four_counts(1638, 3031, 3031, 1638)));
        directed_rows.push_back(mk_row(0, 0, 0, 0, 0, -8388608, 128, 128, 128, 1'b1,
                                       four_counts(3031, 1638, 1638, 3031)));
        directed_rows.push_back(mk_row(0, 0, -8388608, 0, 0, 8388607, 128, 128, 128, 1'b1,
                                       four_counts(1638, 3031, 3031, 1638)));
        // Angle and stick extremes, wide sums and integral wind-up.
        directed_rows.push_back(mk_row(8388607, 0, 0, 0, 0, 0, 128, 128, 128, 1'b0, none));
        directed_rows.push_back(mk_row(-8388608, 0, 0, 0, 0, 0, 128, 128, 128, 1'b0, none));
        directed_rows.push_back(mk_row(0, 8388607, 0, 0, 0, 0, 128, 128, 128, 1'b0, none));
        directed_rows.push_back(mk_row(0, -8388608, 0, 0, 0, 0, 128, 128, 128, 1'b0, none));
        directed_rows.push_back(mk_row(0, 0, 0, 8388607, -8388608, 0, 255, 0, 128, 1'b0,
                                       none));
        directed_rows.push_back(mk_row(0, 0, 0, -8388608, 8388607, 0, 0, 255, 128, 1'b0,
                                       none));
        directed_rows.push_back(mk_row(-8388608, 8388607, 8388607, 8388607, -8388608,
                                       -8388608, 255, 0, 255, 1'b0, none));
        directed_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 255, 0, 1'b0, none));
        directed_rows.push_back(mk_row(256, -256, 512, 0, 0, 0, 129, 127, 127, 1'b0, none));
        directed_rows.push_back(mk_row(256, -256, 512, 0, 0, 0, 129, 127, 127, 1'b0, none));
        directed_rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 128, 128, 128, 1'b0, none));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_tick(directed_rows[i].tick, directed_rows[i].typed,
                      directed_rows[i].counts);
        end
        s_valid <= 1'b0;
        drain_results();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            // New register setting while the block idles.
            for (int r = 0; r < N_REGS; r++) begin
                case (ph)
                    0: data = 22'($urandom_range(0, 16)) + 22'(gain_reg[r] == 0);
                    1: data = (r == REG_HOVER) ? 22'd1000 : 22'd0;
                    2: data = 22'h3FFFFF;
                    3: data = (r == REG_HOVER) ? 22'($urandom_range(1000, 2000))
                                               : 22'($urandom_range(0, 65535));
                    default: data = 22'($urandom);
                endcase
                if (ph == 0) begin
                    case (r)
                        REG_PITCH_KP:    data = CFG_RESET.pitch_kp;
                        REG_PITCH_KD:    data = CFG_RESET.pitch_kd;
                        REG_PITCH_KI:    data = CFG_RESET.pitch_ki;
                        REG_ROLL_KP:     data = CFG_RESET.roll_kp;
                        REG_ROLL_KD:     data = CFG_RESET.roll_kd;
                        REG_ROLL_KI:     data = CFG_RESET.roll_ki;
                        REG_HOVER:       data = 22'd2000;
                        default:         data = 22'd100;
                    endcase
                end
                write_reg(4'(r), data);
            end
            // An index past the register list must be ignored.
            write_reg(4'($urandom_range(N_REGS, 15)), 22'($urandom));
            @(posedge aclk);

            burst_left = 0;
            for (int k = 0; k < PHASE_TICKS; k++) begin
                if (k == PHASE_TICKS / 2) begin
                    // Hold off until every outstanding result has come back.
                    s_valid <= 1'b0;
                    drain_results();
                    @(posedge aclk);
                end else if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    if ($urandom_range(0, 2) != 0) begin
                        s_valid <= 1'b0;
                        repeat ($urandom_range(1, 6)) @(posedge aclk);
                    end
                end
                send_tick(random_tick(), 1'b0, none);
                burst_left--;
            end
            s_valid <= 1'b0;
            drain_results();
        end

        $display("Covered %0d ticks over %0d register settings; %0d result beats checked.",
                 ticks_sent, N_PHASES + 1, beats_checked);
        $display("Beats with motor 0 at a pulse limit: %0d; mismatches: %0d.",
                 saturated_beats, error_count);
        if (error_count == 0 && motor_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #10ms;
        $display("Timeout with %0d results outstanding.", motor_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
